@@ src/pmsc_pkg.sv @@
// shared types and constants for the pid motor speed controller
`timescale 1ns / 1ps

package pmsc_pkg;

    localparam int GAIN_WIDTH   = 16;
    localparam int MARGIN_WIDTH = 7;
    localparam int SPEED_WIDTH  = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int SPEED_CENTRE = 128;
    localparam logic [SPEED_WIDTH-1:0] SPEED_TOP = 8'd255;

    // gain set select carried by the operation field
    localparam logic OP_STRAIGHT = 1'b0;
    localparam logic OP_TURN     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_STRAIGHT     = 3'd0,
        REG_KI_STRAIGHT     = 3'd1,
        REG_KD_STRAIGHT     = 3'd2,
        REG_KP_TURNING      = 3'd3,
        REG_KI_TURNING      = 3'd4,
        REG_KD_TURNING      = 3'd5,
        REG_MARGIN_STRAIGHT = 3'd6,
        REG_MARGIN_TURNING  = 3'd7
    } cfg_index_t;

    // one mode's gains and clamp margin
    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] kp;
        logic signed [GAIN_WIDTH-1:0] ki;
        logic signed [GAIN_WIDTH-1:0] kd;
        logic [MARGIN_WIDTH-1:0]      margin;
    } gain_set_t;

endpackage

@@ src/pmsc_core.sv @@
// pid datapath: error, saturating integral, derivative, gain sum and clamp
`timescale 1ns / 1ps

module pmsc_core #(
    parameter int COUNT_WIDTH    = 24,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  pmsc_pkg::gain_set_t                 gains,
    input  logic                                clear_history,
    input  logic signed [COUNT_WIDTH-1:0]       target_count,
    input  logic signed [COUNT_WIDTH-1:0]       current_count,
    input  logic signed [INTEGRAL_WIDTH-1:0]    integral_sum,
    input  logic signed [COUNT_WIDTH:0]         last_error,
    output logic [pmsc_pkg::SPEED_WIDTH-1:0]    motor_speed,
    output logic signed [COUNT_WIDTH:0]         control_error,
    output logic signed [INTEGRAL_WIDTH-1:0]    integral_next
);
    import pmsc_pkg::*;

    localparam int ERR_W  = COUNT_WIDTH + 1;
    localparam int DER_W  = ERR_W + 1;
    localparam int SUM_W  = ((INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W) + 1;
    localparam int PROD_W = GAIN_WIDTH + ((INTEGRAL_WIDTH > DER_W) ? INTEGRAL_WIDTH : DER_W);
    localparam int ACC_W  = PROD_W + 2;
    localparam int SPD_W  = ACC_W + 1;

    localparam logic signed [SUM_W-1:0] IMAX =
        SUM_W'({1'b0, {(INTEGRAL_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] IMIN = ~IMAX;
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
        ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [SPD_W-1:0] CENTRE_EXT = SPD_W'(SPEED_CENTRE);

    logic signed [INTEGRAL_WIDTH-1:0]    integ_eff;
    logic signed [ERR_W-1:0]             last_eff;
    logic signed [ERR_W-1:0]             err;
    logic signed [SUM_W-1:0]             isum_wide;
    logic signed [INTEGRAL_WIDTH-1:0]    isum;
    logic signed [DER_W-1:0]             deriv;
    logic signed [GAIN_WIDTH+ERR_W-1:0]  p_term;
    logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0] i_term;
    logic signed [GAIN_WIDTH+DER_W-1:0]  d_term;
    logic signed [ACC_W-1:0]             acc;
    logic signed [ACC_W-1:0]             bias;
    logic signed [ACC_W-1:0]             quot;
    logic signed [SPD_W-1:0]             speed_full;
    logic [SPEED_WIDTH-1:0]              top_bound;
    logic signed [SPD_W-1:0]             top_ext;
    logic signed [SPD_W-1:0]             margin_ext;

    // history cleared before this step when asked
    assign integ_eff = clear_history ? '0 : integral_sum;
    assign last_eff  = clear_history ? '0 : last_error;

    assign err = ERR_W'(target_count) - ERR_W'(current_count);

    // saturating integral
    assign isum_wide = SUM_W'(integ_eff) + SUM_W'(err);
    always_comb
    begin
        if (isum_wide > IMAX)
        begin
            isum = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end
        else if (isum_wide < IMIN)
        begin
            isum = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
        end
        else
        begin
            isum = INTEGRAL_WIDTH'(isum_wide);
        end
    end

    assign deriv = DER_W'(err) - DER_W'(last_eff);

    assign p_term = gains.kp * err;
    assign i_term = gains.ki * isum;
    assign d_term = gains.kd * deriv;

    assign acc = ACC_W'(p_term) + ACC_W'(i_term) + ACC_W'(d_term);

    // truncate toward zero: bias negatives before the arithmetic shift
    assign bias = acc[ACC_W-1] ? TRUNC_BIAS : '0;
    assign quot = (acc + bias) >>> GAIN_FRAC_BITS;

    assign speed_full = SPD_W'(quot) + CENTRE_EXT;

    assign top_bound  = SPEED_TOP - {1'b0, gains.margin};
    assign top_ext    = $signed({{(SPD_W-SPEED_WIDTH){1'b0}}, top_bound});
    assign margin_ext = $signed({{(SPD_W-MARGIN_WIDTH){1'b0}}, gains.margin});

    // upper bound wins when both apply
    always_comb
    begin
        if (speed_full >= top_ext)
        begin
            motor_speed = top_bound;
        end
        else if (speed_full <= margin_ext)
        begin
            motor_speed = {1'b0, gains.margin};
        end
        else
        begin
            motor_speed = speed_full[SPEED_WIDTH-1:0];
        end
    end

    assign control_error = err;
    assign integral_next = isum;

endmodule

@@ src/pid_motor_speed_clamped.sv @@
// top level of the pid motor speed controller with output clamp
`timescale 1ns / 1ps

// pid motor speed controller. each item carries a target and a current
// encoder count, a mode bit (0 straight, 1 turn) choosing the gain set and
// clamp margin, and a clear bit that zeroes the integral and the previous
// error before the step. the block returns one item per input: the motor
// speed byte (128 = stop, clamped into [margin, 255 - margin], upper bound
// checked first) and the error target - current. gains are signed q8.8
// by default (GAIN_FRAC_BITS fraction bits); the sum of the three products
// is truncated toward zero. throughput is one item per cycle while
// out_stall is low: the accepting edge loads the input register, the
// multiply/sum/clamp logic, which also closes the integral and
// previous-error loop in that same cycle, feeds the result register,
// which is loaded at the edge on which the result register is free.
// in_stall rises only while both registers hold items and out_stall is
// high. configuration registers are written through cfg_valid/cfg_ready,
// always ready, and must only change while no item is in flight.
module pid_motor_speed_clamped #(
    parameter int COUNT_WIDTH    = 24,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic                                clear_history,
    input  logic signed [COUNT_WIDTH-1:0]       target_count,
    input  logic signed [COUNT_WIDTH-1:0]       current_count,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pmsc_pkg::SPEED_WIDTH-1:0]    motor_speed,
    output logic signed [COUNT_WIDTH:0]         control_error,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pmsc_pkg::*;

    // configuration registers
    logic signed [GAIN_WIDTH-1:0] kp_straight_reg;
    logic signed [GAIN_WIDTH-1:0] ki_straight_reg;
    logic signed [GAIN_WIDTH-1:0] kd_straight_reg;
    logic signed [GAIN_WIDTH-1:0] kp_turning_reg;
    logic signed [GAIN_WIDTH-1:0] ki_turning_reg;
    logic signed [GAIN_WIDTH-1:0] kd_turning_reg;
    logic [MARGIN_WIDTH-1:0]      margin_straight_reg;
    logic [MARGIN_WIDTH-1:0]      margin_turning_reg;

    // input register
    logic                         stage_valid_reg;
    logic                         stage_op_reg;
    logic                         stage_clear_reg;
    logic signed [COUNT_WIDTH-1:0] stage_target_reg;
    logic signed [COUNT_WIDTH-1:0] stage_current_reg;

    // controller history
    logic signed [INTEGRAL_WIDTH-1:0] integral_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_next;
    logic signed [COUNT_WIDTH:0]      last_error_reg;

    // result register
    logic                         out_valid_reg;
    logic [SPEED_WIDTH-1:0]       speed_reg;
    logic [SPEED_WIDTH-1:0]       speed_next;
    logic signed [COUNT_WIDTH:0]  error_reg;
    logic signed [COUNT_WIDTH:0]  error_next;

    gain_set_t gains;
    logic      advance;
    logic      in_take;
    logic      cfg_we;

    // result register frees up when empty or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = stage_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_straight_reg     <= '0;
            ki_straight_reg     <= '0;
            kd_straight_reg     <= '0;
            kp_turning_reg      <= '0;
            ki_turning_reg      <= '0;
            kd_turning_reg      <= '0;
            margin_straight_reg <= '0;
            margin_turning_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_KP_STRAIGHT:     kp_straight_reg     <= cfg_data;
                REG_KI_STRAIGHT:     ki_straight_reg     <= cfg_data;
                REG_KD_STRAIGHT:     kd_straight_reg     <= cfg_data;
                REG_KP_TURNING:      kp_turning_reg      <= cfg_data;
                REG_KI_TURNING:      ki_turning_reg      <= cfg_data;
                REG_KD_TURNING:      kd_turning_reg      <= cfg_data;
                REG_MARGIN_STRAIGHT: margin_straight_reg <= cfg_data[MARGIN_WIDTH-1:0];
                REG_MARGIN_TURNING:  margin_turning_reg  <= cfg_data[MARGIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // pick the gain set for the item in the input register
    always_comb
    begin
        if (stage_op_reg == OP_TURN)
        begin
            gains.kp     = kp_turning_reg;
            gains.ki     = ki_turning_reg;
            gains.kd     = kd_turning_reg;
            gains.margin = margin_turning_reg;
        end
        else
        begin
            gains.kp     = kp_straight_reg;
            gains.ki     = ki_straight_reg;
            gains.kd     = kd_straight_reg;
            gains.margin = margin_straight_reg;
        end
    end

    pmsc_core #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_core (
        .gains          (gains),
        .clear_history  (stage_clear_reg),
        .target_count   (stage_target_reg),
        .current_count  (stage_current_reg),
        .integral_sum   (integral_reg),
        .last_error     (last_error_reg),
        .motor_speed    (speed_next),
        .control_error  (error_next),
        .integral_next  (integral_next)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_op_reg      <= operation;
            stage_clear_reg   <= clear_history;
            stage_target_reg  <= target_count;
            stage_current_reg <= current_count;
        end
    end

    // history moves on exactly when an item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg   <= '0;
            last_error_reg <= '0;
        end
        else if (stage_valid_reg && advance)
        begin
            integral_reg   <= integral_next;
            last_error_reg <= error_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg)
        begin
            speed_reg <= speed_next;
            error_reg <= error_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_speed   = speed_reg;
    assign control_error = error_reg;

    // input side only stalls behind a full, stalled result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result side can move");

    // history holds when no item is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stage_valid_reg && advance) |=> ($stable(integral_reg) && $stable(last_error_reg)))
        else $error("controller history changed without an item");

    // stored previous error matches the error just issued
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && advance) |=> (last_error_reg == control_error))
        else $error("previous error differs from issued error");

    // a taken result with nothing behind it empties the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !stage_valid_reg) |=> !out_valid)
        else $error("result repeated");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the pid motor speed controller with output clamp
`timescale 1ns / 1ps

module testbench;

    import pmsc_pkg::*;

    // block parameters, kept at the default build
    localparam int COUNT_W    = 24;
    localparam int FRAC_W     = 8;
    localparam int INTEGRAL_W = 32;

    // cycles with no item moving on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 4000;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;

    // one input item plus a flag that holds it back until the block has drained
    typedef struct {
        logic                      op;
        logic                      clr;
        logic signed [COUNT_W-1:0] tgt;
        logic signed [COUNT_W-1:0] cur;
        logic                      drain_first;
    } pid_item_t;

    typedef struct {
        logic [SPEED_WIDTH-1:0] speed;
        logic signed [COUNT_W:0] err;
    } pid_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic                      operation     = OP_STRAIGHT;
    logic                      clear_history = 1'b0;
    logic signed [COUNT_W-1:0] target_count  = '0;
    logic signed [COUNT_W-1:0] current_count = '0;

    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic [SPEED_WIDTH-1:0]    motor_speed;
    logic signed [COUNT_W:0]   control_error;

    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;

    // items still to be sent and results still owed by the block
    pid_item_t   pending_items[$];
    pid_result_t expected_results[$];

    // controller state and settings as the block should hold them
    logic signed [GAIN_WIDTH-1:0] gain_kp [2];
    logic signed [GAIN_WIDTH-1:0] gain_ki [2];
    logic signed [GAIN_WIDTH-1:0] gain_kd [2];
    logic [MARGIN_WIDTH-1:0]      clamp_margin [2];
    longint integ_sum  = 0;
    longint prev_error = 0;

    pid_item_t   sent_item;
    pid_result_t next_result;
    pid_result_t oldest_result;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;

    pid_motor_speed_clamped #(
        .COUNT_WIDTH    (COUNT_W),
        .GAIN_FRAC_BITS (FRAC_W),
        .INTEGRAL_WIDTH (INTEGRAL_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .clear_history (clear_history),
        .target_count  (target_count),
        .current_count (current_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_speed   (motor_speed),
        .control_error (control_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one pid step: advances the integral and previous error, returns the result
    task automatic predict_pid_step(input pid_item_t it, output pid_result_t res);
        longint err_now;
        longint isum;
        longint deriv;
        longint kp;
        longint ki;
        longint kd;
        longint acc;
        longint spd;
        longint mrg;
        if (it.clr)
        begin
            integ_sum  = 0;
            prev_error = 0;
        end
        err_now = longint'(it.tgt) - longint'(it.cur);
        // integral saturates at the 32 bit signed limits
        isum = integ_sum + err_now;
        if (isum > INTEG_MAX)
            isum = INTEG_MAX;
        if (isum < INTEG_MIN)
            isum = INTEG_MIN;
        integ_sum = isum;
        deriv = err_now - prev_error;
        kp = gain_kp[it.op];
        ki = gain_ki[it.op];
        kd = gain_kd[it.op];
        // exact q8.8 sum, then division truncates toward zero
        acc = kp * err_now + ki * isum + kd * deriv;
        acc = acc / (longint'(1) <<< FRAC_W);
        spd = SPEED_CENTRE + acc;
        mrg = longint'(clamp_margin[it.op]);
        // upper bound takes priority
        if (spd >= longint'(SPEED_TOP) - mrg)
            spd = longint'(SPEED_TOP) - mrg;
        else if (spd <= mrg)
            spd = mrg;
        prev_error = err_now;
        res.speed = spd[SPEED_WIDTH-1:0];
        res.err   = err_now[COUNT_W:0];
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // one register write, returns on the edge that takes it
    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KP_STRAIGHT:     gain_kp[OP_STRAIGHT] = value;
            REG_KI_STRAIGHT:     gain_ki[OP_STRAIGHT] = value;
            REG_KD_STRAIGHT:     gain_kd[OP_STRAIGHT] = value;
            REG_KP_TURNING:      gain_kp[OP_TURN]     = value;
            REG_KI_TURNING:      gain_ki[OP_TURN]     = value;
            REG_KD_TURNING:      gain_kd[OP_TURN]     = value;
            REG_MARGIN_STRAIGHT: clamp_margin[OP_STRAIGHT] = value[MARGIN_WIDTH-1:0];
            REG_MARGIN_TURNING:  clamp_margin[OP_TURN]     = value[MARGIN_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // writes all eight registers back to back
    task automatic load_settings(input logic [GAIN_WIDTH-1:0] kps, kis, kds, kpt, kit, kdt,
                                 input logic [MARGIN_WIDTH-1:0] ms, mt);
        @(posedge clk);
        write_cfg(REG_KP_STRAIGHT, kps);
        write_cfg(REG_KI_STRAIGHT, kis);
        write_cfg(REG_KD_STRAIGHT, kds);
        write_cfg(REG_KP_TURNING, kpt);
        write_cfg(REG_KI_TURNING, kit);
        write_cfg(REG_KD_TURNING, kdt);
        write_cfg(REG_MARGIN_STRAIGHT, CFG_DATA_W'(ms));
        write_cfg(REG_MARGIN_TURNING, CFG_DATA_W'(mt));
        cfg_valid <= 1'b0;
    endtask

    // waits until every item is sent and every result has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(pending_items.size() == 0 && !in_valid && expected_results.size() == 0));
        // pipeline is two deep, leave a little slack
        repeat (4) @(posedge clk);
    endtask

    function automatic void queue_item(input logic op, input logic clr,
                                       input logic signed [COUNT_W-1:0] tgt,
                                       input logic signed [COUNT_W-1:0] cur,
                                       input logic drain_first);
        pid_item_t it;
        it.op          = op;
        it.clr         = clr;
        it.tgt         = tgt;
        it.cur         = cur;
        it.drain_first = drain_first;
        pending_items.push_back(it);
    endfunction

    function automatic logic signed [COUNT_W-1:0] boundary_count();
        case ($urandom_range(0, 4))
            0:       return COUNT_MAX;
            1:       return COUNT_MIN;
            2:       return '0;
            3:       return '1;
            default: return COUNT_W'(1);
        endcase
    endfunction

    // mostly small errors around a random position, some wild and boundary counts
    function automatic pid_item_t random_item();
        pid_item_t it;
        int sel;
        int delta;
        sel   = $urandom_range(0, 99);
        delta = int'($urandom_range(0, 600)) - 300;
        it.cur = COUNT_W'($urandom);
        if (sel < 70)
            it.tgt = it.cur + COUNT_W'(delta);
        else if (sel < 85)
            it.tgt = COUNT_W'($urandom);
        else
        begin
            it.tgt = boundary_count();
            it.cur = boundary_count();
        end
        it.op          = 1'($urandom_range(0, 1));
        it.clr         = ($urandom_range(0, 99) < 8);
        it.drain_first = ($urandom_range(0, 59) == 0);
        return it;
    endfunction

    function automatic logic [GAIN_WIDTH-1:0] pick_gain();
        int v;
        case ($urandom_range(0, 4))
            0, 1, 2:
            begin
                v = int'($urandom_range(0, 1024)) - 512;
                return GAIN_WIDTH'(v);
            end
            3:
            begin
                v = int'($urandom_range(0, 32)) - 16;
                return GAIN_WIDTH'(v);
            end
            default: return GAIN_WIDTH'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(random_item());
    endtask

    // repeated full-scale errors of one sign, pushing the integral into saturation
    task automatic queue_full_scale(input int n, input logic positive);
        for (int i = 0; i < n; i++)
        begin
            if (positive)
                queue_item(1'($urandom_range(0, 1)), 1'b0, COUNT_MAX, COUNT_MIN, 1'b0);
            else
                queue_item(1'($urandom_range(0, 1)), 1'b0, COUNT_MIN, COUNT_MAX, 1'b0);
        end
    endtask

    // a few small-error items that keep the history going
    task automatic queue_small_steps(input int n);
        pid_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it = random_item();
            it.clr = 1'b0;
            it.tgt = it.cur + COUNT_W'(int'($urandom_range(0, 20)) - 10);
            pending_items.push_back(it);
        end
    endtask

    // driver: takes the next pending item whenever the channel is free
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            // item taken at this edge: predict what it must produce
            if (in_valid && !in_stall)
            begin
                predict_pid_step(sent_item, next_result);
                expected_results.push_back(next_result);
            end
            // a stalled item stays put
            if (!(in_valid && in_stall))
            begin
                if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && expected_results.size() != 0)
                    && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    sent_item = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= sent_item.op;
                    clear_history <= sent_item.clr;
                    target_count  <= sent_item.tgt;
                    current_count <= sent_item.cur;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch($sformatf("unexpected item speed %0d error %0d",
                                            motor_speed, control_error));
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (motor_speed !== oldest_result.speed)
                        flag_mismatch($sformatf("motor_speed expected %0d got %0d",
                                                oldest_result.speed, motor_speed));
                    if (control_error !== oldest_result.err)
                        flag_mismatch($sformatf("control_error expected %0d got %0d",
                                                oldest_result.err, control_error));
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog on channel activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        for (int m = 0; m < 2; m++)
        begin
            gain_kp[m]      = '0;
            gain_ki[m]      = '0;
            gain_kd[m]      = '0;
            clamp_margin[m] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: unit straight gain with a little history, 1.5 turn gain
        // to show truncation toward zero, margins 0 and 20
        sender_idle_pct = 20;
        stall_pct       = 80;
        load_settings(16'sd256, 16'sd4, 16'sd64, 16'sd384, 16'sd0, 16'sd0, 7'd0, 7'd20);
        queue_item(OP_STRAIGHT, 1'b1, 24'sd0, 24'sd0, 1'b0);
        queue_item(OP_STRAIGHT, 1'b1, 24'sd100, 24'sd0, 1'b0);
        queue_item(OP_STRAIGHT, 1'b1, 24'sd0, 24'sd100, 1'b0);
        queue_item(OP_STRAIGHT, 1'b1, 24'sd0, 24'sd129, 1'b0);
        queue_item(OP_STRAIGHT, 1'b0, -24'sd5, -24'sd10, 1'b0);
        queue_item(OP_STRAIGHT, 1'b0, -24'sd5, -24'sd12, 1'b0);
        queue_item(OP_STRAIGHT, 1'b0, -24'sd5, -24'sd2, 1'b0);
        queue_item(OP_STRAIGHT, 1'b1, COUNT_MAX, COUNT_MIN, 1'b0);
        queue_item(OP_STRAIGHT, 1'b1, COUNT_MIN, COUNT_MAX, 1'b0);
        queue_item(OP_STRAIGHT, 1'b0, COUNT_MAX, COUNT_MAX, 1'b0);
        queue_item(OP_STRAIGHT, 1'b0, COUNT_MIN, COUNT_MIN, 1'b0);
        queue_item(OP_STRAIGHT, 1'b1, -24'sd1, 24'sd0, 1'b1);
        queue_item(OP_TURN, 1'b1, -24'sd1, 24'sd0, 1'b0);
        queue_item(OP_TURN, 1'b1, 24'sd1, 24'sd0, 1'b0);
        queue_item(OP_TURN, 1'b1, 24'sd0, 24'sd3, 1'b0);
        queue_item(OP_TURN, 1'b1, 24'sd71, 24'sd0, 1'b0);
        queue_item(OP_TURN, 1'b1, 24'sd72, 24'sd0, 1'b0);
        queue_item(OP_TURN, 1'b1, -24'sd72, 24'sd0, 1'b0);
        queue_item(OP_TURN, 1'b0, 24'sd0, COUNT_MIN, 1'b0);
        queue_item(OP_TURN, 1'b0, COUNT_MIN, 24'sd0, 1'b0);
        wait_drained();

        // random content, margins at both extremes
        load_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                      pick_gain(), 7'd0, 7'd127);
        queue_random(50);
        wait_drained();

        // sender now idles more than the receiver
        sender_idle_pct = 80;
        stall_pct       = 20;
        load_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                      pick_gain(), 7'd127, 7'd0);
        queue_random(50);
        wait_drained();

        // integral saturation: integral gain of one lsb only, so the speed only comes
        // back into range if the integral clipped at its limits
        load_settings(16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 7'd0, 7'd5);
        queue_item(OP_STRAIGHT, 1'b1, COUNT_MAX, COUNT_MIN, 1'b1);
        queue_full_scale(139, 1'b1);
        queue_full_scale(128, 1'b0);
        queue_small_steps(4);
        queue_full_scale(140, 1'b0);
        queue_full_scale(128, 1'b1);
        queue_small_steps(4);
        wait_drained();

        // no idling at all
        sender_idle_pct = 0;
        stall_pct       = 0;
        load_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                      pick_gain(), MARGIN_WIDTH'($urandom_range(0, 127)),
                      MARGIN_WIDTH'($urandom_range(0, 127)));
        queue_random(50);
        wait_drained();

        // extreme gains
        load_settings(16'h7FFF, 16'h8000, pick_gain(), 16'h8000, 16'h7FFF, GAIN_WIDTH'($urandom),
                      MARGIN_WIDTH'($urandom_range(0, 127)),
                      MARGIN_WIDTH'($urandom_range(0, 127)));
        queue_random(50);
        wait_drained();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
